@@ sv/hill_key_recovery_2x2_defines.svh @@
// assertion macros used by the asserting file, the top level
`ifndef HILL_KEY_RECOVERY_2X2_DEFINES_SVH
`define HILL_KEY_RECOVERY_2X2_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HKR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/hkr_pkg.sv @@
`default_nettype none

package hkr_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned LW      = 5;
  localparam int unsigned PW      = 2 * LW;
  localparam int unsigned SW      = PW + 1;
  localparam int unsigned MW      = 12;
  // 2^16 / 26 rounded up, exact quotient for any value below 2^MW
  localparam int unsigned RECIP   = 2521;
  localparam int unsigned RSHIFT  = 16;

  typedef logic [LW-1:0] letter_t;

  // inverse of each residue, zero where none exists
  localparam letter_t UNIT_INV [LETTERS] = '{
    5'd0, 5'd1, 5'd0, 5'd9, 5'd0, 5'd21, 5'd0, 5'd15, 5'd0, 5'd3, 5'd0, 5'd19, 5'd0,
    5'd0, 5'd0, 5'd7, 5'd0, 5'd23, 5'd0, 5'd11, 5'd0, 5'd5, 5'd0, 5'd17, 5'd0, 5'd25
  };

  typedef struct packed {
    letter_t plain1_first;
    letter_t plain1_second;
    letter_t cipher1_first;
    letter_t cipher1_second;
    letter_t plain2_first;
    letter_t plain2_second;
    letter_t cipher2_first;
    letter_t cipher2_second;
  } request_t;

  typedef struct packed {
    letter_t c00;
    letter_t c10;
    letter_t c01;
    letter_t c11;
  } cipher_t;

  typedef struct packed {
    letter_t p00;
    letter_t p10;
    letter_t p01;
    letter_t p11;
  } plain_t;

  typedef struct packed {
    plain_t          p;
    cipher_t         c;
    logic [PW-1:0]   pa;
    logic [PW-1:0]   pb;
  } s1_t;

  typedef struct packed {
    plain_t  p;
    cipher_t c;
    letter_t dinv;
    logic    singular;
  } s2_t;

  typedef struct packed {
    cipher_t       c;
    logic [PW-1:0] m00;
    logic [PW-1:0] m01;
    logic [PW-1:0] m10;
    logic [PW-1:0] m11;
    logic          singular;
  } s3_t;

  typedef struct packed {
    cipher_t c;
    letter_t i00;
    letter_t i01;
    letter_t i10;
    letter_t i11;
    logic    singular;
  } s4_t;

  typedef struct packed {
    logic [SW-1:0] s00;
    logic [SW-1:0] s01;
    logic [SW-1:0] s10;
    logic [SW-1:0] s11;
    logic          singular;
  } s5_t;

  typedef struct packed {
    letter_t k00;
    letter_t k01;
    letter_t k10;
    letter_t k11;
    logic    singular;
  } key_t;

  // out-of-range letter codes wrap by one subtract
  function automatic letter_t letter_fix(input letter_t x);
    letter_t r;
    r = (x >= LW'(LETTERS)) ? LW'(x - LW'(LETTERS)) : x;
    return r;
  endfunction

  function automatic letter_t neg26(input letter_t x);
    letter_t r;
    r = (x == '0) ? '0 : LW'(LW'(LETTERS) - x);
    return r;
  endfunction

  // reciprocal multiply then back-subtract, exact below 2^MW
  function automatic letter_t mod26(input logic [MW-1:0] v);
    logic [MW+RSHIFT-1:0] prod;
    logic [MW-1:0]        q;
    logic [MW-1:0]        r;
    prod = (MW+RSHIFT)'(v) * (MW+RSHIFT)'(RECIP);
    q    = MW'(prod >> RSHIFT);
    r    = v - MW'(q * MW'(LETTERS));
    return r[LW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/hkr_in_if.sv @@
`default_nettype none

interface hkr_in_if;
  logic             valid;
  logic             ready;
  hkr_pkg::letter_t plain1_first;
  hkr_pkg::letter_t plain1_second;
  hkr_pkg::letter_t cipher1_first;
  hkr_pkg::letter_t cipher1_second;
  hkr_pkg::letter_t plain2_first;
  hkr_pkg::letter_t plain2_second;
  hkr_pkg::letter_t cipher2_first;
  hkr_pkg::letter_t cipher2_second;

  modport source (
    output valid, plain1_first, plain1_second, cipher1_first, cipher1_second,
           plain2_first, plain2_second, cipher2_first, cipher2_second,
    input  ready
  );
  modport sink (
    input  valid, plain1_first, plain1_second, cipher1_first, cipher1_second,
           plain2_first, plain2_second, cipher2_first, cipher2_second,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/hkr_out_if.sv @@
`default_nettype none

interface hkr_out_if;
  logic             valid;
  logic             ready;
  hkr_pkg::letter_t key_row0_col0;
  hkr_pkg::letter_t key_row0_col1;
  hkr_pkg::letter_t key_row1_col0;
  hkr_pkg::letter_t key_row1_col1;
  logic             singular;

  modport source (
    output valid, key_row0_col0, key_row0_col1, key_row1_col0, key_row1_col1, singular,
    input  ready
  );
  modport sink (
    input  valid, key_row0_col0, key_row0_col1, key_row1_col0, key_row1_col1, singular,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/hkr_det.sv @@
`default_nettype none

// stages 1-2: letter wrap, determinant products, determinant and unit lookup
module hkr_det (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire hkr_pkg::request_t in_data,
  output logic                   out_valid,
  output hkr_pkg::s2_t           out_data
);
  import hkr_pkg::*;

  logic          v1_r, v1_nxt;
  s1_t           s1_r, s1_nxt;
  logic          v2_r, v2_nxt;
  s2_t           s2_r, s2_nxt;
  logic [MW-1:0] det_raw;
  letter_t       det;

  always_comb begin
    s1_nxt.p.p00 = letter_fix(in_data.plain1_first);
    s1_nxt.p.p10 = letter_fix(in_data.plain1_second);
    s1_nxt.p.p01 = letter_fix(in_data.plain2_first);
    s1_nxt.p.p11 = letter_fix(in_data.plain2_second);
    s1_nxt.c.c00 = letter_fix(in_data.cipher1_first);
    s1_nxt.c.c10 = letter_fix(in_data.cipher1_second);
    s1_nxt.c.c01 = letter_fix(in_data.cipher2_first);
    s1_nxt.c.c11 = letter_fix(in_data.cipher2_second);
    s1_nxt.pa    = PW'(s1_nxt.p.p00) * PW'(s1_nxt.p.p11);
    s1_nxt.pb    = PW'(s1_nxt.p.p01) * PW'(s1_nxt.p.p10);
    v1_nxt       = en ? in_valid : v1_r;
  end

  // offset by 26*26 keeps the difference positive
  assign det_raw = MW'(s1_r.pa) + MW'(LETTERS * LETTERS) - MW'(s1_r.pb);
  assign det     = mod26(det_raw);

  always_comb begin
    s2_nxt.p        = s1_r.p;
    s2_nxt.c        = s1_r.c;
    s2_nxt.dinv     = UNIT_INV[det];
    s2_nxt.singular = (UNIT_INV[det] == '0);
    v2_nxt          = en ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = s2_r;
endmodule

`default_nettype wire

@@ sv/hkr_inv.sv @@
`default_nettype none

// stages 3-4: adjugate times determinant inverse, reduced
module hkr_inv (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire hkr_pkg::s2_t in_data,
  output logic              out_valid,
  output hkr_pkg::s4_t      out_data
);
  import hkr_pkg::*;

  logic v3_r, v3_nxt;
  s3_t  s3_r, s3_nxt;
  logic v4_r, v4_nxt;
  s4_t  s4_r, s4_nxt;

  always_comb begin
    s3_nxt.c        = in_data.c;
    s3_nxt.m00      = PW'(in_data.p.p11) * PW'(in_data.dinv);
    s3_nxt.m01      = PW'(neg26(in_data.p.p01)) * PW'(in_data.dinv);
    s3_nxt.m10      = PW'(neg26(in_data.p.p10)) * PW'(in_data.dinv);
    s3_nxt.m11      = PW'(in_data.p.p00) * PW'(in_data.dinv);
    s3_nxt.singular = in_data.singular;
    v3_nxt          = en ? in_valid : v3_r;
  end

  always_comb begin
    s4_nxt.c        = s3_r.c;
    s4_nxt.i00      = mod26(MW'(s3_r.m00));
    s4_nxt.i01      = mod26(MW'(s3_r.m01));
    s4_nxt.i10      = mod26(MW'(s3_r.m10));
    s4_nxt.i11      = mod26(MW'(s3_r.m11));
    s4_nxt.singular = s3_r.singular;
    v4_nxt          = en ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;
endmodule

`default_nettype wire

@@ sv/hkr_mul.sv @@
`default_nettype none

// stages 5-6: ciphertext times inverse, reduced into the output register
module hkr_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire hkr_pkg::s4_t in_data,
  output logic              out_valid,
  output hkr_pkg::key_t     out_data
);
  import hkr_pkg::*;

  logic v5_r, v5_nxt;
  s5_t  s5_r, s5_nxt;
  logic v6_r, v6_nxt;
  key_t k_r, k_nxt;

  always_comb begin
    s5_nxt.s00 = SW'(in_data.c.c00) * SW'(in_data.i00) + SW'(in_data.c.c01) * SW'(in_data.i10);
    s5_nxt.s01 = SW'(in_data.c.c00) * SW'(in_data.i01) + SW'(in_data.c.c01) * SW'(in_data.i11);
    s5_nxt.s10 = SW'(in_data.c.c10) * SW'(in_data.i00) + SW'(in_data.c.c11) * SW'(in_data.i10);
    s5_nxt.s11 = SW'(in_data.c.c10) * SW'(in_data.i01) + SW'(in_data.c.c11) * SW'(in_data.i11);
    s5_nxt.singular = in_data.singular;
    v5_nxt          = en ? in_valid : v5_r;
  end

  always_comb begin
    k_nxt.k00      = mod26(MW'(s5_r.s00));
    k_nxt.k01      = mod26(MW'(s5_r.s01));
    k_nxt.k10      = mod26(MW'(s5_r.s10));
    k_nxt.k11      = mod26(MW'(s5_r.s11));
    k_nxt.singular = s5_r.singular;
    v6_nxt         = en ? v5_r : v6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v5_r <= v5_nxt;
      v6_r <= v6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s5_nxt;
      k_r  <= k_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = k_r;
endmodule

`default_nettype wire

@@ sv/hill_key_recovery_2x2.sv @@
// pipeline: six register stages, the first loaded at the accepting edge, the last being the
//   result register
// throughput: one request per cycle unless the full result register is not taken
// stall: every stage holds, bubbles included, while the result register is full and not taken
// reset: synchronous active-low rst_n clears every stage valid bit, payload is not reset
`default_nettype none

`include "hill_key_recovery_2x2_defines.svh"

module hill_key_recovery_2x2 (
  input  wire logic clk,
  input  wire logic rst_n,
  hkr_in_if.sink    in_ch,
  hkr_out_if.source out_ch
);
  import hkr_pkg::*;

  // one advance for the whole pipe, taken whenever the output slot frees up
  logic     en;
  request_t req;
  logic     det_valid;
  s2_t      det_data;
  logic     inv_valid;
  s4_t      inv_data;
  logic     key_valid;
  key_t     key_data;

  assign en          = !key_valid || out_ch.ready;
  assign in_ch.ready = en;

  // gather the request fields; letters are wrapped inside stage 1
  assign req.plain1_first   = in_ch.plain1_first;
  assign req.plain1_second  = in_ch.plain1_second;
  assign req.cipher1_first  = in_ch.cipher1_first;
  assign req.cipher1_second = in_ch.cipher1_second;
  assign req.plain2_first   = in_ch.plain2_first;
  assign req.plain2_second  = in_ch.plain2_second;
  assign req.cipher2_first  = in_ch.cipher2_first;
  assign req.cipher2_second = in_ch.cipher2_second;

  // determinant and its inverse from the unit table
  hkr_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_data   (req),
    .out_valid (det_valid),
    .out_data  (det_data)
  );

  // inverse of the plaintext matrix; a zero inverse makes it all zero
  hkr_inv u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (det_valid),
    .in_data   (det_data),
    .out_valid (inv_valid),
    .out_data  (inv_data)
  );

  // key = ciphertext matrix times inverse, last stage is the output register
  hkr_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (inv_valid),
    .in_data   (inv_data),
    .out_valid (key_valid),
    .out_data  (key_data)
  );

  assign out_ch.valid         = key_valid;
  assign out_ch.key_row0_col0 = key_data.k00;
  assign out_ch.key_row0_col1 = key_data.k01;
  assign out_ch.key_row1_col0 = key_data.k10;
  assign out_ch.key_row1_col1 = key_data.k11;
  assign out_ch.singular      = key_data.singular;

  // a singular plaintext must leave an all-zero key
  `HKR_ASSERT_NOW(a_singular_zero_key, key_valid && key_data.singular,
    key_data.k00 == '0 && key_data.k01 == '0 && key_data.k10 == '0 && key_data.k11 == '0,
    "singular result with nonzero key")
  // reduction must always land inside the alphabet
  `HKR_ASSERT_NOW(a_key_in_range, key_valid,
    key_data.k00 < LW'(LETTERS) && key_data.k01 < LW'(LETTERS) &&
    key_data.k10 < LW'(LETTERS) && key_data.k11 < LW'(LETTERS),
    "key entry out of range")
  // a stalled pipe keeps the stage 2 and stage 4 valid bits and the result valid
  `HKR_ASSERT_NEXT(a_stall_holds, !en,
    $stable(det_valid) && $stable(inv_valid) && key_valid,
    "pipe moved during stall")
endmodule

`default_nettype wire
